// File: hw/rtl/idchk_pkg.sv
// ----------------------------------------------------------------------------
// idchk_pkg
// Types, constants and small functions shared by the identity number checker.
// ----------------------------------------------------------------------------
package idchk_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    localparam logic [4:0] POS_LAST_WEIGHTED = 5'd16;
    localparam logic [4:0] POS_SHORT_END     = 5'd14;
    localparam logic [4:0] POS_LONG_END      = 5'd17;
    localparam logic [4:0] POS_MAX           = 5'd31;

    typedef struct packed {
        logic [7:0] id_char;
        logic       last_char;
    } beat_t;

    // weight of the digit at a position of the 18-character form
    function automatic logic [3:0] digit_weight(input logic [4:0] pos);
        logic [3:0] w;
        case (pos)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // expected check character for a weighted sum mod 11
    function automatic logic [7:0] check_char(input logic [3:0] sum);
        logic [7:0] c;
        case (sum)
            4'd0:    c = 8'h31;
            4'd1:    c = 8'h30;
            4'd2:    c = CHAR_UPPER_X;
            4'd3:    c = 8'h39;
            4'd4:    c = 8'h38;
            4'd5:    c = 8'h37;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h35;
            4'd8:    c = 8'h34;
            4'd9:    c = 8'h33;
            4'd10:   c = 8'h32;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // v mod 11 for v <= 100, reciprocal 187/2048
    function automatic logic [3:0] mod11(input logic [6:0] v);
        logic [14:0] p;
        logic [6:0]  q;
        logic [6:0]  qx;
        p  = 15'(v) * 15'd187;
        q  = 7'(p[14:11]);
        qx = 7'(q * 7'd11);
        return 4'(v - qx);
    endfunction

    function automatic logic date_ok(input logic [6:0] month, input logic [6:0] day,
                                     input logic leap);
        logic [6:0] lim;
        case (month)
            7'd2:    lim = leap ? 7'd29 : 7'd28;
            7'd4,
            7'd6,
            7'd9,
            7'd11:   lim = 7'd30;
            default: lim = 7'd31;
        endcase
        return (month >= 7'd1) && (month <= 7'd12) && (day >= 7'd1) && (day <= lim);
    endfunction

endpackage

// File: hw/rtl/idchk_in_reg.sv
// ----------------------------------------------------------------------------
// idchk_in_reg
// Input register: holds one character beat until the core takes it.
// ----------------------------------------------------------------------------
module idchk_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  idchk_pkg::beat_t in_beat,
    output logic           beat_vld,
    output idchk_pkg::beat_t beat,
    input  logic           beat_take
);
    import idchk_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    beat_t beat_reg;

    assign in_stall = vld_reg && !beat_take;
    assign beat_vld = vld_reg;
    assign beat     = beat_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (beat_take)
        begin
            vld_next = 1'b0;
        end
        if (in_valid && !in_stall)
        begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

// File: hw/rtl/idchk_core.sv
// ----------------------------------------------------------------------------
// idchk_core
// Per-number state (position, weighted sum, date digits) and result register.
// ----------------------------------------------------------------------------
module idchk_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           beat_vld,
    input  idchk_pkg::beat_t beat,
    output logic           beat_take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           id_valid
);
    import idchk_pkg::*;

    logic [4:0] pos_reg,  pos_next;
    logic [3:0] sum_reg,  sum_next;
    logic       nd_reg,   nd_next;
    // two-digit fields at positions 6-7, 8-9, 10-11, 12-13
    logic [6:0] f67_reg,   f67_next;
    logic [6:0] f89_reg,   f89_next;
    logic [6:0] f1011_reg, f1011_next;
    logic [6:0] f1213_reg, f1213_next;
    logic       ovld_reg,  ovld_next;
    logic       res_reg;

    logic       is_dig;
    logic [3:0] dig;
    logic [6:0] prod;
    logic [6:0] sum_raw;
    logic       weighted;
    logic [7:0] cu;
    logic       leap_long;
    logic       leap_short;
    logic       ok_long;
    logic       ok_short;
    logic       result;

    function automatic logic [6:0] push_digit(input logic [6:0] f, input logic [3:0] d);
        return 7'(f * 7'd10) + 7'(d);
    endfunction

    assign beat_take = beat_vld && !(ovld_reg && out_stall);
    assign out_valid = ovld_reg;
    assign id_valid  = res_reg;

    always_comb
    begin
        is_dig   = (beat.id_char >= CHAR_ZERO) && (beat.id_char <= CHAR_NINE);
        dig      = is_dig ? 4'(beat.id_char - CHAR_ZERO) : 4'd0;
        weighted = (pos_reg <= POS_LAST_WEIGHTED);
        prod     = 7'(dig) * 7'(digit_weight(pos_reg));
        sum_raw  = 7'(sum_reg) + prod;

        sum_next = (weighted && is_dig) ? mod11(sum_raw) : sum_reg;
        nd_next  = nd_reg | (weighted && !is_dig);
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 5'd1;

        f67_next   = f67_reg;
        f89_next   = f89_reg;
        f1011_next = f1011_reg;
        f1213_next = f1213_reg;
        if (is_dig)
        begin
            if (pos_reg == 5'd6 || pos_reg == 5'd7)
            begin
                f67_next = push_digit(f67_reg, dig);
            end
            if (pos_reg == 5'd8 || pos_reg == 5'd9)
            begin
                f89_next = push_digit(f89_reg, dig);
            end
            if (pos_reg == 5'd10 || pos_reg == 5'd11)
            begin
                f1011_next = push_digit(f1011_reg, dig);
            end
            if (pos_reg == 5'd12 || pos_reg == 5'd13)
            begin
                f1213_next = push_digit(f1213_reg, dig);
            end
        end

        // leap: long year = f67*100 + f89; short year = 1900 + f67
        cu         = (beat.id_char == CHAR_LOWER_X) ? CHAR_UPPER_X : beat.id_char;
        leap_long  = (f89_reg != 7'd0) ? (f89_reg[1:0] == 2'd0) : (f67_reg[1:0] == 2'd0);
        leap_short = (f67_reg != 7'd0) && (f67_reg[1:0] == 2'd0);
        ok_long    = (pos_reg == POS_LONG_END) && (cu == check_char(sum_reg))
                     && date_ok(f1011_reg, f1213_reg, leap_long);
        ok_short   = (pos_reg == POS_SHORT_END) && date_ok(f89_reg, f1011_reg, leap_short);
        result     = !nd_next && (ok_long || ok_short);

        ovld_next = ovld_reg && out_stall;
        if (beat_take && beat.last_char)
        begin
            ovld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 5'd0;
            sum_reg   <= 4'd0;
            nd_reg    <= 1'b0;
            f67_reg   <= 7'd0;
            f89_reg   <= 7'd0;
            f1011_reg <= 7'd0;
            f1213_reg <= 7'd0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
            if (beat_take)
            begin
                if (beat.last_char)
                begin
                    pos_reg   <= 5'd0;
                    sum_reg   <= 4'd0;
                    nd_reg    <= 1'b0;
                    f67_reg   <= 7'd0;
                    f89_reg   <= 7'd0;
                    f1011_reg <= 7'd0;
                    f1213_reg <= 7'd0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    sum_reg   <= sum_next;
                    nd_reg    <= nd_next;
                    f67_reg   <= f67_next;
                    f89_reg   <= f89_next;
                    f1011_reg <= f1011_next;
                    f1213_reg <= f1213_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && beat.last_char)
        begin
            res_reg <= result;
        end
    end

endmodule

// File: hw/rtl/id_number_check_digit_validator.sv
// A finished number passes the input register, then the result register.
// Throughput: one beat per cycle when no result is stalled; set by both registers.
// Stall on the result side backs up through the input register one beat deep.
// Reset (rst_n low, async) clears all per-number state and both valid flags.
// ----------------------------------------------------------------------------
// id_number_check_digit_validator
// Checks length, digits, birth date and the 18-character form's check character.
// ----------------------------------------------------------------------------
module id_number_check_digit_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] id_char,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       id_valid
);
    import idchk_pkg::*;

    beat_t in_beat;
    beat_t beat;
    logic  beat_vld;
    logic  beat_take;

    assign in_beat.id_char   = id_char;
    assign in_beat.last_char = last_char;

    idchk_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .beat_vld  (beat_vld),
        .beat      (beat),
        .beat_take (beat_take)
    );

    idchk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_vld  (beat_vld),
        .beat      (beat),
        .beat_take (beat_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .id_valid  (id_valid)
    );

endmodule

// File: hw/rtl/idchk_checker.sv
// ----------------------------------------------------------------------------
// idchk_checker
// Port-level checks for the identity number checker.
// ----------------------------------------------------------------------------
module idchk_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic last_char,
    input logic out_valid,
    input logic out_stall,
    input logic id_valid
);
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_last_acc;
    logic       out_acc;

    assign in_last_acc = in_valid && !in_stall && last_char;
    assign out_acc     = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_last_acc && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_last_acc && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without result backpressure");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without a finished number");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two numbers in flight");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(id_valid)))
        else $error("stalled result changed");

endmodule

bind id_number_check_digit_validator idchk_checker u_idchk_checker (.*);
